### hdl/lsig_pkg.sv
// Shared types and constants for the learnable sigmoid element.
// Used by every module of the block but lsig_queue; depends on nothing.
package lsig_pkg;

  localparam logic [1:0] OPC_FWD = 2'd0;
  localparam logic [1:0] OPC_BWD = 2'd1;
  localparam logic [1:0] OPC_CLR = 2'd2;

  localparam logic [1:0] REG_SLOPE    = 2'd0;
  localparam logic [1:0] REG_BIAS     = 2'd1;
  localparam logic [1:0] REG_PARAM_EN = 2'd2;
  localparam logic [1:0] REG_INPUT_EN = 2'd3;

  localparam logic signed [31:0] SLOPE_RST = 32'sd32768;
  localparam logic signed [31:0] BIAS_RST  = 32'sd1966080;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [1:0] {
    KIND_FWD,
    KIND_BWD,
    KIND_CLR,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] sample;
    logic [16:0]        sig_value;
    logic signed [31:0] grad_first;
    logic signed [31:0] grad_second;
  } item_t;

  typedef struct packed {
    logic [16:0]        sig_out;
    logic [16:0]        comp_out;
    logic signed [31:0] input_grad;
    logic signed [47:0] slope_grad_sum;
    logic signed [47:0] bias_grad_sum;
  } result_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] bias;
    logic               param_grad_en;
    logic               input_grad_en;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [32:0] diff;
    logic signed [32:0] dlt;
    logic [16:0]        sv;
  } mid_t;

endpackage

### hdl/lsig_queue.sv
// Small first-in first-out queue in registers with show-ahead read.
// Standalone; used between the front and back parts and at the output.
module lsig_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [W-1:0]                 wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [W-1:0]                 rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

### hdl/lsig_front.sv
// Front part: accepts items, decodes the opcode and forms the differences.
// Depends on lsig_pkg and lsig_queue.
module lsig_front (
  input  logic                 clk,
  input  logic                 rst,
  input  lsig_pkg::cfg_t       cfg,
  input  logic                 push,
  input  lsig_pkg::item_t      item,
  output logic                 full,
  input  logic                 mid_pop,
  output lsig_pkg::mid_t       mid_item,
  output logic                 mid_empty
);
  lsig_pkg::mid_t entry;
  logic [$clog2(lsig_pkg::MID_DEPTH+1)-1:0] mid_cnt;

  always_comb begin
    unique case (item.opcode)
      lsig_pkg::OPC_FWD: entry.kind = lsig_pkg::KIND_FWD;
      lsig_pkg::OPC_BWD: entry.kind = lsig_pkg::KIND_BWD;
      lsig_pkg::OPC_CLR: entry.kind = lsig_pkg::KIND_CLR;
      default:           entry.kind = lsig_pkg::KIND_NOP;
    endcase
    entry.diff = 33'(item.sample) - 33'(cfg.bias);
    entry.dlt  = 33'(item.grad_first) - 33'(item.grad_second);
    entry.sv   = (item.sig_value > lsig_pkg::ONE_Q16) ? lsig_pkg::ONE_Q16 : item.sig_value;
  end

  lsig_queue #(
    .W($bits(lsig_pkg::mid_t)),
    .DEPTH(lsig_pkg::MID_DEPTH)
  ) u_mid (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(entry),
    .full(full),
    .pop(mid_pop),
    .rdata(mid_item),
    .empty(mid_empty),
    .count(mid_cnt)
  );

  logic unused_cnt;
  assign unused_cnt = ^mid_cnt;
endmodule

### hdl/lsig_back.sv
// Back part: five-stage datapath for forward, backward and clear, the gradient
// accumulators and the result queue. Depends on lsig_pkg and lsig_queue.
module lsig_back #(
  parameter int LUT_SEGMENTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lsig_pkg::cfg_t       cfg,
  input  lsig_pkg::mid_t       mid_item,
  input  logic                 mid_empty,
  output logic                 mid_pop,
  output lsig_pkg::result_t    result,
  output logic                 empty,
  input  logic                 pop
);
  localparam int IDXW = $clog2(LUT_SEGMENTS+1);
  localparam int POSW = 36 + IDXW;
  localparam int CNTW = $clog2(lsig_pkg::OUT_DEPTH+1);
  localparam logic signed [64:0] LIM = 65'sh8_0000_0000;

  logic [16:0] tbl [0:LUT_SEGMENTS];

  for (genvar k = 0; k <= LUT_SEGMENTS; k++) begin : g_tbl
    localparam longint NUM = 16 * k - 8 * LUT_SEGMENTS;
    localparam longint unsigned MAG = (NUM < 0) ? -NUM : NUM;
    localparam longint unsigned A  = (MAG << 30) / LUT_SEGMENTS;
    localparam longint unsigned Y  = A >> 8;
    localparam longint unsigned Y2 = (Y * Y) >> 30;
    localparam longint unsigned Y3 = (Y2 * Y) >> 30;
    localparam longint unsigned Y4 = (Y3 * Y) >> 30;
    localparam longint unsigned E0 = (64'd1 << 30) - Y + Y2 / 2 - Y3 / 6 + Y4 / 24;
    localparam longint unsigned E1 = (E0 * E0) >> 30;
    localparam longint unsigned E2 = (E1 * E1) >> 30;
    localparam longint unsigned E3 = (E2 * E2) >> 30;
    localparam longint unsigned E4 = (E3 * E3) >> 30;
    localparam longint unsigned E5 = (E4 * E4) >> 30;
    localparam longint unsigned E6 = (E5 * E5) >> 30;
    localparam longint unsigned E7 = (E6 * E6) >> 30;
    localparam longint unsigned E8 = (E7 * E7) >> 30;
    localparam longint unsigned DEN = (64'd1 << 30) + E8;
    localparam longint unsigned SP = ((64'd1 << 46) + DEN / 2) / DEN;
    localparam longint unsigned VAL = (NUM < 0) ? 64'd65536 - SP : SP;
    assign tbl[k] = VAL[16:0];
  end

  logic [5:1] vld;
  logic [CNTW-1:0] out_cnt;
  logic out_full;

  assign mid_pop = !mid_empty &&
                   (({1'b0, CNTW'($countones(vld))} + {1'b0, out_cnt})
                    < (CNTW+1)'(lsig_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:1], mid_pop};
    end
  end

  lsig_pkg::kind_t    kind1, kind2, kind3, kind4, kind5;
  logic signed [32:0] diff1, diff2, diff3;
  logic signed [32:0] dlt1;
  logic signed [64:0] t1;
  logic [31:0]        q1;
  logic               lo2, hi2;
  logic [POSW-1:0]    pos2;
  logic signed [64:0] dq2;
  logic [16:0]        lo3, hi3;
  logic [15:0]        f3;
  logic signed [32:0] g3;
  logic [33:0]        plo4;
  logic [32:0]        phi4;
  logic signed [64:0] sg4;
  logic signed [65:0] xg4;
  logic [16:0]        sig5;
  logic signed [49:0] p5, st5;

  logic [IDXW-1:0]    idx;
  logic [IDXW-1:0]    idx_nx;
  logic [35:0]        pofs;

  assign pofs   = 36'(t1 + LIM);
  assign idx    = pos2[36 +: IDXW];
  assign idx_nx = idx + 1'b1;

  always_ff @(posedge clk) begin
    kind1 <= mid_item.kind;
    diff1 <= mid_item.diff;
    dlt1  <= mid_item.dlt;
    t1    <= 65'(cfg.slope) * 65'(mid_item.diff);
    q1    <= 32'(mid_item.sv) * 32'(lsig_pkg::ONE_Q16 - mid_item.sv);

    kind2 <= kind1;
    diff2 <= diff1;
    lo2   <= t1 < -LIM;
    hi2   <= t1 >= LIM;
    pos2  <= POSW'(pofs) * POSW'(LUT_SEGMENTS);
    dq2   <= 65'(dlt1) * 65'($signed({1'b0, q1}));

    kind3 <= kind2;
    diff3 <= diff2;
    if (lo2) begin
      lo3 <= tbl[0];
      hi3 <= tbl[0];
      f3  <= '0;
    end else if (hi2) begin
      lo3 <= tbl[LUT_SEGMENTS];
      hi3 <= tbl[LUT_SEGMENTS];
      f3  <= '0;
    end else begin
      lo3 <= tbl[idx];
      hi3 <= tbl[idx_nx];
      f3  <= pos2[20 +: 16];
    end
    g3 <= 33'((dq2 + 65'sd2147483648) >>> 32);

    kind4 <= kind3;
    plo4  <= 34'(lo3) * 34'(lsig_pkg::ONE_Q16 - {1'b0, f3});
    phi4  <= 33'(hi3) * 33'(f3);
    sg4   <= 65'(cfg.slope) * 65'(g3);
    xg4   <= 66'(diff3) * 66'(g3);

    kind5 <= kind4;
    sig5  <= 17'((35'(plo4) + 35'(phi4) + 35'd32768) >> 16);
    p5    <= 50'((sg4 + 65'sd32768) >>> 16);
    st5   <= 50'((xg4 + 66'sd32768) >>> 16);
  end

  logic signed [47:0] acc_s, acc_b;
  logic signed [47:0] acc_s_next, acc_b_next;
  logic signed [50:0] sum_s, sum_b;
  logic signed [47:0] sat_s, sat_b;
  lsig_pkg::result_t  res;

  always_comb begin
    sum_s = 51'(acc_s) + 51'(st5);
    sum_b = 51'(acc_b) - 51'(p5);
    if (sum_s > 51'(lsig_pkg::ACC_MAX)) begin
      sat_s = lsig_pkg::ACC_MAX;
    end else if (sum_s < 51'(lsig_pkg::ACC_MIN)) begin
      sat_s = lsig_pkg::ACC_MIN;
    end else begin
      sat_s = 48'(sum_s);
    end
    if (sum_b > 51'(lsig_pkg::ACC_MAX)) begin
      sat_b = lsig_pkg::ACC_MAX;
    end else if (sum_b < 51'(lsig_pkg::ACC_MIN)) begin
      sat_b = lsig_pkg::ACC_MIN;
    end else begin
      sat_b = 48'(sum_b);
    end

    acc_s_next     = acc_s;
    acc_b_next     = acc_b;
    res.sig_out    = '0;
    res.comp_out   = '0;
    res.input_grad = '0;
    case (kind5)
      lsig_pkg::KIND_FWD: begin
        res.sig_out  = sig5;
        res.comp_out = lsig_pkg::ONE_Q16 - sig5;
      end
      lsig_pkg::KIND_BWD: begin
        if (cfg.input_grad_en) begin
          if (p5 > 50'sd2147483647) begin
            res.input_grad = 32'sh7FFF_FFFF;
          end else if (p5 < -50'sd2147483648) begin
            res.input_grad = 32'sh8000_0000;
          end else begin
            res.input_grad = 32'(p5);
          end
        end
        if (cfg.param_grad_en) begin
          acc_s_next = sat_s;
          acc_b_next = sat_b;
        end
      end
      lsig_pkg::KIND_CLR: begin
        acc_s_next = '0;
        acc_b_next = '0;
      end
      default: begin
      end
    endcase
    res.slope_grad_sum = acc_s_next;
    res.bias_grad_sum  = acc_b_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_s <= '0;
      acc_b <= '0;
    end else if (vld[5]) begin
      acc_s <= acc_s_next;
      acc_b <= acc_b_next;
    end
  end

  lsig_queue #(
    .W($bits(lsig_pkg::result_t)),
    .DEPTH(lsig_pkg::OUT_DEPTH)
  ) u_out (
    .clk(clk),
    .rst(rst),
    .push(vld[5]),
    .wdata(res),
    .full(out_full),
    .pop(pop),
    .rdata(result),
    .empty(empty),
    .count(out_cnt)
  );

  logic unused_full;
  assign unused_full = out_full;
endmodule

### hdl/learnable_sigmoid_fwd_bwd.sv
// Top level of the learnable sigmoid element with gradient accumulation.
// Holds the configuration registers; depends on lsig_pkg, lsig_front, lsig_back.
//
// Usage:
//   Input queue side: drive item and push; the item is taken at an edge where
//   push is high and full is low. Opcodes: forward, backward, clear.
//   Result queue side: while empty is low, result holds the oldest result;
//   pulse pop to take it. One result per item, in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0 slope, 1 bias, 2 param gradient enable, 3 input
//   gradient enable; other indexes are dropped. Write only while idle.
// Timing:
//   An accepted item passes through the four-entry queue between front and
//   back, the back datapath stages and the result queue before it is visible.
//   One item per cycle is sustained while results are popped; the back part
//   issues only when the eight-entry result queue has room for everything in
//   flight, so a stalled receiver fills that queue, then the middle queue,
//   then raises full. Nothing is dropped.
// Reset: rst clears queues, accumulators and registers to their defaults.
module learnable_sigmoid_fwd_bwd #(
  parameter int LUT_SEGMENTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsig_pkg::item_t    item,
  output logic               full,
  output lsig_pkg::result_t  result,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  lsig_pkg::cfg_t cfg;
  lsig_pkg::mid_t mid_item;
  logic           mid_empty;
  logic           mid_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope         <= lsig_pkg::SLOPE_RST;
      cfg.bias          <= lsig_pkg::BIAS_RST;
      cfg.param_grad_en <= 1'b1;
      cfg.input_grad_en <= 1'b1;
    end else if (cfg_valid && cfg_index[7:2] == '0) begin
      unique case (cfg_index[1:0])
        lsig_pkg::REG_SLOPE:    cfg.slope         <= cfg_data;
        lsig_pkg::REG_BIAS:     cfg.bias          <= cfg_data;
        lsig_pkg::REG_PARAM_EN: cfg.param_grad_en <= cfg_data[0];
        lsig_pkg::REG_INPUT_EN: cfg.input_grad_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lsig_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .push(push),
    .item(item),
    .full(full),
    .mid_pop(mid_pop),
    .mid_item(mid_item),
    .mid_empty(mid_empty)
  );

  lsig_back #(
    .LUT_SEGMENTS(LUT_SEGMENTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .mid_item(mid_item),
    .mid_empty(mid_empty),
    .mid_pop(mid_pop),
    .result(result),
    .empty(empty),
    .pop(pop)
  );
endmodule

### hdl/lsig_checker.sv
// Port-level checks for the learnable sigmoid element, bound to the top level.
// Depends on lsig_pkg and learnable_sigmoid_fwd_bwd.
module lsig_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input lsig_pkg::result_t  result,
  input logic               empty,
  input logic               pop
);
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_complement: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ({1'b0, result.sig_out} + {1'b0, result.comp_out} == 18'd65536)
            || (result.sig_out == '0 && result.comp_out == '0))
    else $error("sigmoid and complement disagree");

  a_fwd_no_grad: assert property (@(posedge clk) disable iff (rst)
    !empty && result.sig_out != '0 |-> result.input_grad == '0)
    else $error("forward result carries an input gradient");
endmodule

bind learnable_sigmoid_fwd_bwd lsig_checker u_lsig_checker (.*);
